// ===== hw/rtl/ccl_pkg.sv =====
`timescale 1ns / 1ps

package ccl_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_LABELS = 512;

	localparam int DIM_W   = 10;
	localparam int LBL_W   = 9;
	localparam int NXT_W   = 10;
	localparam int ADDR_W  = 18;
	localparam int TOTAL_W = 2 * DIM_W;
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;

	localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_LOAD    = 2'd1,
		CMD_RESOLVE = 2'd2,
		CMD_READ    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_ORDER = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		RET_MA,
		RET_MB,
		RET_RES
	} ret_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EXEC,
		S_NB0,
		S_NB1,
		S_NB2,
		S_NB3,
		S_DECIDE,
		S_MSEL,
		S_FADDR,
		S_FCHK,
		S_MWR,
		S_RSEL,
		S_RRES,
		S_RWR,
		S_RDS,
		S_RDF,
		S_FIN
	} state_t;

endpackage

// ===== hw/rtl/connected_component_labeller.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    cmd, pixel_value, pixel_index
// out      source     out_valid / out_ready  label, component_count, overflow, status
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Request flow: start, a border or background pixel and a rejected request go straight to
// the final state; an interior foreground pixel reads its neighbors, writes its label and
// runs two union-find finds per merge; resolve runs a find per provisional label; read looks
// up the pixel label, then its map entry. The finds walk the single parent table read port.
// Reset clears control state only; the label, parent and map memories are never cleared.
// in_ready is high only in idle; a finished result waits in the output register and
// holds the sequencer in its final state until the output side frees that register.

module connected_component_labeller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  pixel_value,
	input  logic [17:0] pixel_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  label,
	output logic [8:0]  component_count,
	output logic        overflow,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	import ccl_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q;
	ret_t   ret_q;

	logic [DIM_W-1:0]   fw_q, fh_q, cur_w_q, cur_h_q, row_q, col_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  pos_q;
	logic [NXT_W-1:0]   next_q, l_q;
	logic [LBL_W-1:0]   count_q, comp_q, lab_q, left_q, x_q, ra_q, res_lab_q;
	logic [LBL_W-1:0]   nb_q [4];
	logic [2:0]         m_q;
	logic               ovf_q;
	status_t            res_st_q;
	cmd_t               cmd_q;
	logic [7:0]         val_q;
	logic [ADDR_W-1:0]  idx_q;

	logic               out_valid_q, out_ovf_q;
	logic [LBL_W-1:0]   out_lab_q, out_cnt_q;
	status_t            out_st_q;

	// memories
	logic [LBL_W-1:0]  label_mem [DEPTH];
	logic [LBL_W-1:0]  parent_mem [MAX_LABELS];
	logic [LBL_W-1:0]  map_mem [MAX_LABELS];
	logic              ls_we, par_we, map_we;
	logic [ADDR_W-1:0] ls_addr;
	logic [LBL_W-1:0]  ls_wd, ls_rd_q;
	logic [LBL_W-1:0]  par_waddr, par_raddr, par_wd, par_rd_q;
	logic [LBL_W-1:0]  map_waddr, map_raddr, map_wd, map_rd_q;

	// combinational helpers
	logic [DIM_W-1:0]   cw, ch;
	logic               interior, can_load, can_resolve, out_free;
	logic [LBL_W-1:0]   first_nb, nb_m, lab_new;
	logic               new_ok;

	assign out_free = !out_valid_q || out_ready;

	// clamp the frame size
	always_comb begin
		cw = fw_q;
		ch = fh_q;
		if (fw_q < DIM_W'(3)) cw = DIM_W'(3);
		else if (fw_q > DIM_W'(MAX_WIDTH)) cw = DIM_W'(MAX_WIDTH);
		if (fh_q < DIM_W'(3)) ch = DIM_W'(3);
		else if (fh_q > DIM_W'(MAX_HEIGHT)) ch = DIM_W'(MAX_HEIGHT);
	end

	assign interior = (row_q != '0) && (col_q != '0) &&
		((row_q + 1'b1) < cur_h_q) && ((col_q + 1'b1) < cur_w_q);
	assign can_load    = (phase_q == PH_LOAD) && (row_q < cur_h_q);
	assign can_resolve = ((phase_q == PH_LOAD) && (row_q >= cur_h_q)) || (phase_q == PH_DONE);
	assign nb_m        = nb_q[m_q[1:0]];
	assign new_ok      = next_q < NXT_W'(MAX_LABELS);

	// pick the first nonzero neighbor label
	always_comb begin
		priority if (nb_q[0] != '0) first_nb = nb_q[0];
		else if (nb_q[1] != '0) first_nb = nb_q[1];
		else if (nb_q[2] != '0) first_nb = nb_q[2];
		else first_nb = nb_q[3];
		lab_new = first_nb;
		if (first_nb == '0 && new_ok) lab_new = next_q[LBL_W-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		ls_we     = 1'b0;
		ls_addr   = pos_q;
		ls_wd     = '0;
		par_we    = 1'b0;
		par_waddr = lab_new;
		par_wd    = lab_new;
		par_raddr = x_q;
		map_we    = 1'b0;
		map_waddr = l_q[LBL_W-1:0];
		map_wd    = count_q + 1'b1;
		map_raddr = x_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				unique case (cmd_q)
					CMD_START: state_d = S_FIN;
					CMD_LOAD: begin
						if (!can_load) state_d = S_FIN;
						else if (interior && val_q == 8'd0) state_d = S_NB0;
						else begin
							ls_we   = 1'b1;
							state_d = S_FIN;
						end
					end
					CMD_RESOLVE: state_d = can_resolve ? S_RSEL : S_FIN;
					CMD_READ: begin
						ls_addr = idx_q;
						if (phase_q == PH_DONE && TOTAL_W'(idx_q) < total_q) state_d = S_RDS;
						else state_d = S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_NB0: begin
				ls_addr = pos_q - ADDR_W'(cur_w_q) - 1'b1;
				state_d = S_NB1;
			end
			S_NB1: begin
				ls_addr = pos_q - ADDR_W'(cur_w_q);
				state_d = S_NB2;
			end
			S_NB2: begin
				ls_addr = pos_q - ADDR_W'(cur_w_q) + 1'b1;
				state_d = S_NB3;
			end
			S_NB3: state_d = S_DECIDE;
			S_DECIDE: begin
				ls_we   = 1'b1;
				ls_wd   = lab_new;
				par_we  = (first_nb == '0) && new_ok;
				state_d = S_MSEL;
			end
			S_MSEL: begin
				if (m_q == 3'd4) state_d = S_FIN;
				else if (nb_m != '0 && nb_m != lab_q) state_d = S_FADDR;
			end
			S_FADDR: state_d = S_FCHK;
			S_FCHK: begin
				par_raddr = par_rd_q;
				if (par_rd_q == x_q) begin
					unique case (ret_q)
						RET_MA:  state_d = S_FADDR;
						RET_MB:  state_d = S_MWR;
						RET_RES: state_d = S_RRES;
						default: state_d = S_FIN;
					endcase
				end
			end
			S_MWR: begin
				par_we    = (ra_q != x_q);
				par_waddr = (ra_q < x_q) ? x_q : ra_q;
				par_wd    = (ra_q < x_q) ? ra_q : x_q;
				state_d   = S_MSEL;
			end
			S_RSEL: state_d = (l_q >= next_q) ? S_FIN : S_FADDR;
			S_RRES: begin
				if (x_q == l_q[LBL_W-1:0]) begin
					map_we  = 1'b1;
					state_d = S_RSEL;
				end else state_d = S_RWR;
			end
			S_RWR: begin
				map_we  = 1'b1;
				map_wd  = map_rd_q;
				state_d = S_RSEL;
			end
			S_RDS: begin
				map_raddr = ls_rd_q;
				state_d   = (ls_rd_q == '0) ? S_FIN : S_RDF;
			end
			S_RDF: state_d = S_FIN;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory arrays
	always_ff @(posedge clk) begin
		if (ls_we) label_mem[ls_addr] <= ls_wd;
		ls_rd_q <= label_mem[ls_addr];
	end

	always_ff @(posedge clk) begin
		if (par_we) parent_mem[par_waddr] <= par_wd;
		par_rd_q <= parent_mem[par_raddr];
	end

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_waddr] <= map_wd;
		map_rd_q <= map_mem[map_raddr];
	end

	// request payload latch
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_t'(cmd);
			val_q <= pixel_value;
			idx_q <= pixel_index;
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= DIM_W'(MAX_WIDTH);
			fh_q      <= DIM_W'(MAX_HEIGHT);
			cur_w_q   <= '0;
			cur_h_q   <= '0;
			total_q   <= '0;
			phase_q   <= PH_IDLE;
			next_q    <= NXT_W'(1);
			pos_q     <= '0;
			row_q     <= '0;
			col_q     <= '0;
			comp_q    <= '0;
			ovf_q     <= 1'b0;
			res_st_q  <= STAT_OK;
			res_lab_q <= '0;
			ret_q     <= RET_MA;
			m_q       <= '0;
			l_q       <= '0;
			count_q   <= '0;
			lab_q     <= '0;
			left_q    <= '0;
			x_q       <= '0;
			ra_q      <= '0;
			for (int i = 0; i < 4; i++) nb_q[i] <= '0;
		end else begin
			// take register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  fw_q <= cfg_data;
					REG_FRAME_HEIGHT: fh_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_EXEC: begin
					res_st_q  <= STAT_OK;
					res_lab_q <= '0;
					unique case (cmd_q)
						CMD_START: begin
							cur_w_q <= cw;
							cur_h_q <= ch;
							total_q <= TOTAL_W'(cw) * TOTAL_W'(ch);
							next_q  <= NXT_W'(1);
							pos_q   <= '0;
							row_q   <= '0;
							col_q   <= '0;
							comp_q  <= '0;
							ovf_q   <= 1'b0;
							left_q  <= '0;
							phase_q <= PH_LOAD;
						end
						CMD_LOAD: begin
							if (!can_load) res_st_q <= STAT_ORDER;
							else if (!(interior && val_q == 8'd0)) begin
								left_q <= '0;
								pos_q  <= pos_q + 1'b1;
								if (col_q + 1'b1 == cur_w_q) begin
									col_q <= '0;
									row_q <= row_q + 1'b1;
								end else col_q <= col_q + 1'b1;
							end
						end
						CMD_RESOLVE: begin
							if (!can_resolve) res_st_q <= STAT_ORDER;
							else begin
								l_q     <= NXT_W'(1);
								count_q <= '0;
								phase_q <= PH_DONE;
							end
						end
						CMD_READ: begin
							if (phase_q != PH_DONE) res_st_q <= STAT_ORDER;
							else if (TOTAL_W'(idx_q) >= total_q) res_st_q <= STAT_RANGE;
						end
						default: ;
					endcase
				end
				S_NB0: nb_q[3] <= left_q;
				S_NB1: nb_q[0] <= ls_rd_q;
				S_NB2: nb_q[1] <= ls_rd_q;
				S_NB3: nb_q[2] <= ls_rd_q;
				S_DECIDE: begin
					lab_q  <= lab_new;
					left_q <= lab_new;
					m_q    <= '0;
					if (first_nb == '0) begin
						if (new_ok) next_q <= next_q + 1'b1;
						else ovf_q <= 1'b1;
					end
					pos_q <= pos_q + 1'b1;
					if (col_q + 1'b1 == cur_w_q) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else col_q <= col_q + 1'b1;
				end
				S_MSEL: begin
					if (m_q != 3'd4) begin
						if (nb_m != '0 && nb_m != lab_q) begin
							x_q   <= lab_q;
							ret_q <= RET_MA;
						end else m_q <= m_q + 1'b1;
					end
				end
				S_FCHK: begin
					if (par_rd_q != x_q) x_q <= par_rd_q;
					else if (ret_q == RET_MA) begin
						ra_q  <= x_q;
						x_q   <= nb_m;
						ret_q <= RET_MB;
					end
				end
				S_MWR: m_q <= m_q + 1'b1;
				S_RSEL: begin
					if (l_q >= next_q) comp_q <= count_q;
					else begin
						x_q   <= l_q[LBL_W-1:0];
						ret_q <= RET_RES;
					end
				end
				S_RRES: begin
					if (x_q == l_q[LBL_W-1:0]) begin
						count_q <= count_q + 1'b1;
						l_q     <= l_q + 1'b1;
					end
				end
				S_RWR: l_q <= l_q + 1'b1;
				S_RDF: res_lab_q <= map_rd_q;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_lab_q   <= '0;
			out_cnt_q   <= '0;
			out_ovf_q   <= 1'b0;
			out_st_q    <= STAT_OK;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
				out_lab_q   <= res_lab_q;
				out_cnt_q   <= comp_q;
				out_ovf_q   <= ovf_q;
				out_st_q    <= res_st_q;
			end else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign label           = out_lab_q;
	assign component_count = out_cnt_q;
	assign overflow        = out_ovf_q;
	assign status          = out_st_q;

	// checks
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted request did not start execution");
	a_next_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= NXT_W'(MAX_LABELS) && next_q != '0)
		else $error("provisional label counter out of range");
	a_parent_down: assert property (@(posedge clk) disable iff (!arst_n)
		par_we |-> par_wd <= par_waddr)
		else $error("parent link points to a larger label");
	a_done_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE |-> row_q >= cur_h_q)
		else $error("resolved before frame fully loaded");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		NXT_W'(comp_q) < next_q)
		else $error("component count exceeds labels issued");

endmodule

// ===== verif/ccl_checker.sv =====
`timescale 1ns / 1ps

module ccl_checker
	import ccl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  pixel_value,
	input  logic [17:0] pixel_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [8:0]  label,
	input  logic [8:0]  component_count,
	input  logic        overflow,
	input  logic [1:0]  status,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	output int          fail_count,
	output int          pending,
	output int          checked
);

	typedef struct packed {
		logic [8:0] lbl;
		logic [8:0] count;
		logic       ovf;
		status_t    st;
	} answer_t;

	answer_t answer_q[$];

	logic [LBL_W-1:0] pix_lbl [DEPTH];
	logic [LBL_W-1:0] parent  [MAX_LABELS];
	logic [LBL_W-1:0] dense   [MAX_LABELS];

	int     next_lbl, pos, comp_total;
	bit     ovf_flag;
	int     reg_w, reg_h, cur_w, cur_h;
	phase_t ph;
	int     fails, seen;

	function automatic int fit_dim(int v, int hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int root_of(int x);
		int steps;
		steps = 0;
		x = x % MAX_LABELS;
		while (parent[x] != x && steps < MAX_LABELS) begin
			x = parent[x] % MAX_LABELS;
			steps++;
		end
		return x;
	endfunction

	function automatic void unite(int a, int b);
		int ra, rb;
		ra = root_of(a);
		rb = root_of(b);
		if (ra < rb) parent[rb] = LBL_W'(ra);
		else if (rb < ra) parent[ra] = LBL_W'(rb);
	endfunction

	// Label one pixel from its four already-loaded neighbors
	function automatic void label_pixel(logic [7:0] v);
		int r, c, lab;
		int nb [4];
		r = pos / cur_w;
		c = pos % cur_w;
		lab = 0;
		if (v == 8'd0 && r >= 1 && c >= 1 && r + 1 < cur_h && c + 1 < cur_w) begin
			nb[0] = pix_lbl[pos - cur_w - 1];
			nb[1] = pix_lbl[pos - cur_w];
			nb[2] = pix_lbl[pos - cur_w + 1];
			nb[3] = pix_lbl[pos - 1];
			for (int i = 0; i < 4 && lab == 0; i++) lab = nb[i];
			if (lab == 0) begin
				if (next_lbl < MAX_LABELS) begin
					lab = next_lbl;
					parent[lab] = LBL_W'(lab);
					next_lbl++;
				end else begin
					ovf_flag = 1'b1;
				end
			end else begin
				for (int i = 0; i < 4; i++)
					if (nb[i] != 0 && nb[i] != lab) unite(lab, nb[i]);
			end
		end
		pix_lbl[pos] = LBL_W'(lab);
		pos++;
	endfunction

	// Number the merged sets densely by their smallest label
	function automatic void renumber();
		int cnt, rt;
		cnt = 0;
		dense[0] = '0;
		for (int l = 1; l < next_lbl && l < MAX_LABELS; l++) begin
			rt = root_of(l);
			if (rt == l) begin
				cnt++;
				dense[l] = LBL_W'(cnt);
			end else begin
				dense[l] = dense[rt];
			end
		end
		comp_total = cnt;
	endfunction

	function automatic answer_t predict(cmd_t c, logic [7:0] v, logic [17:0] idx);
		answer_t a;
		int n;
		a.lbl = '0;
		a.st = STAT_OK;
		n = cur_w * cur_h;
		case (c)
			CMD_START: begin
				cur_w = fit_dim(reg_w, MAX_WIDTH);
				cur_h = fit_dim(reg_h, MAX_HEIGHT);
				next_lbl = 1;
				pos = 0;
				comp_total = 0;
				ovf_flag = 1'b0;
				ph = PH_LOAD;
			end
			CMD_LOAD: begin
				if (ph == PH_LOAD && pos < n) label_pixel(v);
				else a.st = STAT_ORDER;
			end
			CMD_RESOLVE: begin
				if ((ph == PH_LOAD && pos >= n) || ph == PH_DONE) begin
					renumber();
					ph = PH_DONE;
				end else begin
					a.st = STAT_ORDER;
				end
			end
			default: begin
				if (ph != PH_DONE) a.st = STAT_ORDER;
				else if (idx >= n) a.st = STAT_RANGE;
				else a.lbl = dense[pix_lbl[idx] % MAX_LABELS];
			end
		endcase
		a.count = comp_total[8:0];
		a.ovf = ovf_flag;
		return a;
	endfunction

	// Compare finished results, then predict the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			answer_q.delete();
			next_lbl = 1;
			pos = 0;
			comp_total = 0;
			ovf_flag = 1'b0;
			reg_w = 512;
			reg_h = 512;
			cur_w = 0;
			cur_h = 0;
			ph = PH_IDLE;
			fails = 0;
			seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					$error("result with no request pending");
					fails++;
				end else begin
					e = answer_q.pop_front();
					seen++;
					if (label !== e.lbl) begin
						$error("label expected %0d actual %0d", e.lbl, label);
						fails++;
					end
					if (component_count !== e.count) begin
						$error("component_count expected %0d actual %0d", e.count,
							component_count);
						fails++;
					end
					if (overflow !== e.ovf) begin
						$error("overflow expected %0d actual %0d", e.ovf, overflow);
						fails++;
					end
					if (status !== e.st) begin
						$error("status expected %0d actual %0d", e.st, status);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				answer_q.push_back(predict(cmd_t'(cmd), pixel_value, pixel_index));
			if (cfg_we) begin
				if (cfg_index == REG_FRAME_WIDTH) reg_w = cfg_data;
				else reg_h = cfg_data;
			end
		end
		fail_count <= fails;
		pending    <= answer_q.size();
		checked    <= seen;
	end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ccl_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_START;
	logic [7:0]  pixel_value = '0;
	logic [17:0] pixel_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [8:0]  label;
	logic [8:0]  component_count;
	logic        overflow;
	logic [1:0]  status;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_FRAME_WIDTH;
	logic [9:0]  cfg_data = '0;

	int fail_count, pending, checked;
	int idle_pct = 0, stall_pct = 0;
	int hold_asks = 0, hold_served = 0;
	int requests = 0, frames = 0, cycles = 0;
	int fw, fh;

	connected_component_labeller dut (.*);

	ccl_checker chk (.*);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Drive out_ready: random stalls, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one request and hold it until accepted
	task automatic send(cmd_t c, logic [7:0] v, logic [17:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= c;
		pixel_value <= v;
		pixel_index <= idx;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		requests++;
	endtask

	// Drop valid and drain every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_frame(logic [9:0] w, logic [9:0] h);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		fw = (w < 3) ? 3 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		fh = (h < 3) ? 3 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
	endtask

	// One frame: load with occasional noise, resolve, read back
	task automatic run_frame(int fg_pct, bit grid);
		int n, i, r, c;
		logic [7:0] v;
		n = fw * fh;
		frames++;
		send(CMD_START, 8'($urandom), 18'($urandom));
		i = 0;
		while (i < n) begin
			if (!grid && $urandom_range(199) == 0) begin
				case ($urandom_range(2))
					0: send(CMD_RESOLVE, 8'($urandom), 18'($urandom));
					1: send(CMD_READ, 8'($urandom), 18'($urandom_range(n - 1)));
					default: begin
						send(CMD_START, 8'($urandom), 18'($urandom));
						i = 0;
					end
				endcase
			end else begin
				r = i / fw;
				c = i % fw;
				if (grid) v = (r % 2 == 1 && c % 2 == 1) ? 8'd0 : 8'($urandom_range(1, 255));
				else v = ($urandom_range(99) < fg_pct) ? 8'd0 : 8'($urandom_range(1, 255));
				send(CMD_LOAD, v, 18'($urandom));
				i++;
			end
		end
		if ($urandom_range(3) == 0) send(CMD_LOAD, 8'd0, 18'($urandom));
		if ($urandom_range(3) == 0) send(CMD_READ, 8'($urandom), 18'($urandom_range(n - 1)));
		send(CMD_RESOLVE, 8'($urandom), 18'($urandom));
		repeat ($urandom_range(4, 12)) begin
			if ($urandom_range(4) == 0) send(CMD_READ, 8'($urandom), 18'($urandom));
			else send(CMD_READ, 8'($urandom), 18'($urandom_range(n - 1)));
		end
		if ($urandom_range(2) == 0) begin
			send(CMD_RESOLVE, 8'($urandom), 18'($urandom));
			send(CMD_READ, 8'($urandom), 18'($urandom_range(n - 1)));
		end
	endtask

	initial begin
		int base;
		int fg_choice [4];
		fg_choice = '{10, 40, 70, 95};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out-of-order requests straight after reset
		send(CMD_READ, 8'h00, 18'h3FFFF);
		send(CMD_LOAD, 8'h00, 18'h00000);
		send(CMD_RESOLVE, 8'hFF, 18'h00000);

		// Smallest frame from sizes below the range, one lone blob in the middle
		set_frame(10'd0, 10'd0);
		frames++;
		send(CMD_START, 8'h00, 18'h0);
		send(CMD_LOAD, 8'hFF, 18'h0);
		send(CMD_LOAD, 8'h00, 18'h0);
		send(CMD_LOAD, 8'h80, 18'h0);
		send(CMD_LOAD, 8'h01, 18'h0);
		send(CMD_READ, 8'h00, 18'd4);
		send(CMD_LOAD, 8'h00, 18'h0);
		send(CMD_LOAD, 8'h7F, 18'h0);
		send(CMD_LOAD, 8'h00, 18'h0);
		send(CMD_LOAD, 8'hFE, 18'h0);
		send(CMD_LOAD, 8'h00, 18'h0);
		send(CMD_READ, 8'h00, 18'd4);
		send(CMD_RESOLVE, 8'h00, 18'h0);
		send(CMD_READ, 8'h00, 18'd4);
		send(CMD_READ, 8'h00, 18'd0);
		send(CMD_READ, 8'h00, 18'd9);
		send(CMD_READ, 8'h00, 18'h3FFFF);
		send(CMD_RESOLVE, 8'h00, 18'h0);
		send(CMD_READ, 8'h00, 18'd4);

		// Oversized frame clamps to the largest, so a short load cannot be resolved
		set_frame(10'd1023, 10'd1023);
		frames++;
		send(CMD_START, 8'h00, 18'h0);
		repeat (5) send(CMD_LOAD, 8'h00, 18'h0);
		send(CMD_RESOLVE, 8'h00, 18'h0);
		send(CMD_READ, 8'h00, 18'd0);

		// Random phases, each opening with one thin, tall or patterned frame
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 85; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 85; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			base = requests;
			case (p)
				0: set_frame(10'd60, 10'd3);
				1: set_frame(10'd3, 10'd60);
				2: set_frame(10'd16, 10'd16);
				default: set_frame(10'd0, 10'd40);
			endcase
			if (p == 0) hold_asks++;
			run_frame(fg_choice[$urandom_range(3)], p == 2);
			while (requests - base < 375) begin
				set_frame(10'($urandom_range(0, 24)), 10'($urandom_range(0, 24)));
				run_frame(fg_choice[$urandom_range(3)], 1'b0);
			end
		end

		drain();
		$display("Ran %0d requests over %0d frames; %0d results checked across four idle mixes.",
			requests, frames, checked);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
